// ===== hdl/context_model_symbol_counter_assert.svh =====
// assertion macros for the context model symbol counter
`ifndef CONTEXT_MODEL_SYMBOL_COUNTER_ASSERT_SVH
`define CONTEXT_MODEL_SYMBOL_COUNTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only outside reset
`define CMSC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked at every edge, reset included
`define CMSC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CMSC_ASSERT(label, prop, msg)
`define CMSC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== hdl/cmsc_pkg.sv =====
package cmsc_pkg;

   localparam int ORDER_MAX  = 2;
   localparam int COUNT_BITS = 32;

   localparam int ALPHABET   = 26;
   localparam int CTX_SLOTS  = ALPHABET ** ORDER_MAX;
   localparam int SYM_SLOTS  = CTX_SLOTS * ALPHABET;
   localparam int HIST_DEPTH = ORDER_MAX;

   localparam int CHAR_W     = 8;
   localparam int LETTER_W   = 5;
   localparam int CTX_W      = $clog2(CTX_SLOTS);
   localparam int SYM_W      = $clog2(SYM_SLOTS);
   localparam int ORDER_W    = 2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] ADDR_CONTEXT_ORDER = CSR_ADDR_W'(0);
   localparam logic [ORDER_W-1:0]    ORDER_RESET        = ORDER_W'(1);

   localparam logic [CHAR_W-1:0] CHAR_CASE_BIT = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z  = 8'h7a;

   localparam logic [COUNT_BITS-1:0] SYM_COUNT_INIT = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] CTX_TOTAL_INIT = COUNT_BITS'(0);

   // controller to datapath
   typedef struct packed {
      logic clear;     // write init values at the sweep address
      logic capture;   // take the item, shift history
      logic update;    // write back incremented counts, load result
   } cmsc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic is_letter;
   } cmsc_status_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] r;
      r = (v == '1) ? v : v + COUNT_BITS'(1);
      return r;
   endfunction

endpackage

// ===== hdl/cmsc_ram.sv =====
module cmsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/cmsc_ctrl.sv =====
module cmsc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  cmsc_pkg::cmsc_status_type status,
   output cmsc_pkg::cmsc_cmd_type    cmd,
   output logic                     busy
);
   import cmsc_pkg::*;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // non-letters are taken and dropped here
            if (start && status.is_letter) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hdl/cmsc_datapath.sv =====
module cmsc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cmsc_pkg::cmsc_cmd_type                cmd,
   output cmsc_pkg::cmsc_status_type             status,
   input  logic [cmsc_pkg::ORDER_W-1:0]          context_order,
   input  logic [cmsc_pkg::CHAR_W-1:0]           req_char_in,
   output logic                                 rsp_strobe,
   output logic [cmsc_pkg::LETTER_W-1:0]         rsp_letter_index,
   output logic [cmsc_pkg::CTX_W-1:0]            rsp_context_index,
   output logic [cmsc_pkg::COUNT_BITS-1:0]       rsp_symbol_count,
   output logic [cmsc_pkg::COUNT_BITS-1:0]       rsp_context_total
);
   import cmsc_pkg::*;

   // letter decode
   logic [CHAR_W-1:0]   char_lower;
   logic                is_letter;
   logic [LETTER_W-1:0] letter;

   assign char_lower = req_char_in | CHAR_CASE_BIT;
   assign is_letter  = (char_lower >= CHAR_LOWER_A) && (char_lower <= CHAR_LOWER_Z);
   assign letter     = LETTER_W'(char_lower - CHAR_LOWER_A);

   // letter history, entry 0 newest
   logic [LETTER_W-1:0] hist_ff [HIST_DEPTH];

   logic [ORDER_W-1:0] order_eff;
   logic [CTX_W-1:0]   ctx_in;
   logic [SYM_W-1:0]   sym_in;

   always_comb begin
      order_eff = (int'(context_order) > ORDER_MAX) ? ORDER_W'(ORDER_MAX) : context_order;
      ctx_in    = '0;
      for (int i = HIST_DEPTH - 1; i >= 0; i--) begin
         if (i < int'(order_eff)) begin
            ctx_in = CTX_W'(int'(ctx_in) * ALPHABET) + CTX_W'(hist_ff[i]);
         end
      end
      sym_in = SYM_W'(int'(ctx_in) * ALPHABET) + SYM_W'(letter);
   end

   logic [LETTER_W-1:0] letter_ff;
   logic [CTX_W-1:0]    ctx_ff;
   logic [SYM_W-1:0]    sym_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (cmd.capture) begin
         hist_ff[0] <= letter;
         for (int i = 1; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         letter_ff <= letter;
         ctx_ff    <= ctx_in;
         sym_ff    <= sym_in;
      end
   end

   // init sweep over the count memories
   logic [SYM_W-1:0] clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear && !status.clear_last) begin
         clear_addr_ff <= clear_addr_ff + SYM_W'(1);
      end
   end

   assign status.clear_last = (clear_addr_ff == SYM_W'(SYM_SLOTS - 1));
   assign status.is_letter  = is_letter;

   // count memories
   logic                  sym_we;
   logic [SYM_W-1:0]      sym_waddr;
   logic [COUNT_BITS-1:0] sym_wdata;
   logic [COUNT_BITS-1:0] sym_rdata;
   logic                  ctx_we;
   logic [CTX_W-1:0]      ctx_waddr;
   logic [COUNT_BITS-1:0] ctx_wdata;
   logic [COUNT_BITS-1:0] ctx_rdata;
   logic [COUNT_BITS-1:0] sym_next;
   logic [COUNT_BITS-1:0] ctx_next;

   assign sym_next = sat_inc(sym_rdata);
   assign ctx_next = sat_inc(ctx_rdata);

   always_comb begin
      sym_we    = cmd.clear || cmd.update;
      sym_waddr = cmd.clear ? clear_addr_ff : sym_ff;
      sym_wdata = cmd.clear ? SYM_COUNT_INIT : sym_next;
      ctx_we    = (cmd.clear && (int'(clear_addr_ff) < CTX_SLOTS)) || cmd.update;
      ctx_waddr = cmd.clear ? clear_addr_ff[CTX_W-1:0] : ctx_ff;
      ctx_wdata = cmd.clear ? CTX_TOTAL_INIT : ctx_next;
   end

   cmsc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (SYM_SLOTS)
   ) u_sym_ram (
      .clock (clock),
      .we    (sym_we),
      .waddr (sym_waddr),
      .wdata (sym_wdata),
      .raddr (sym_ff),
      .rdata (sym_rdata)
   );

   cmsc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (CTX_SLOTS)
   ) u_ctx_ram (
      .clock (clock),
      .we    (ctx_we),
      .waddr (ctx_waddr),
      .wdata (ctx_wdata),
      .raddr (ctx_ff),
      .rdata (ctx_rdata)
   );

   // result register
   logic                  strobe_ff;
   logic [LETTER_W-1:0]   out_letter_ff;
   logic [CTX_W-1:0]      out_ctx_ff;
   logic [COUNT_BITS-1:0] out_sym_ff;
   logic [COUNT_BITS-1:0] out_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         out_letter_ff <= letter_ff;
         out_ctx_ff    <= ctx_ff;
         out_sym_ff    <= sym_next;
         out_total_ff  <= ctx_next;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_letter_index  = out_letter_ff;
   assign rsp_context_index = out_ctx_ff;
   assign rsp_symbol_count  = out_sym_ff;
   assign rsp_context_total = out_total_ff;

endmodule

// ===== hdl/context_model_symbol_counter.sv =====
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+-------------------------------------------
// request   | in        | start, busy             | req_char_in
// response  | out       | rsp_strobe (one cycle)  | rsp_letter_index, rsp_context_index,
//           |           |                         | rsp_symbol_count, rsp_context_total
// csr       | in/out    | psel, penable, pready   | paddr, pwrite, pwdata, prdata
//
// a letter passes through capture, count memory read and read-modify-write;
// the result strobe comes in the cycle after and busy is already low then
// a non-letter transfer is taken while idle and gives no result
// the registered-read ports of the two count memories set the per-letter time
// after reset busy stays high while the init sweep writes
// every symbol count to one and every context total to zero; csr writes work
// the receiver cannot stall: every strobe is one finished transfer
`include "context_model_symbol_counter_assert.svh"

module context_model_symbol_counter (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [cmsc_pkg::CHAR_W-1:0]          req_char_in,
   // response channel
   output logic                                rsp_strobe,
   output logic [cmsc_pkg::LETTER_W-1:0]        rsp_letter_index,
   output logic [cmsc_pkg::CTX_W-1:0]           rsp_context_index,
   output logic [cmsc_pkg::COUNT_BITS-1:0]      rsp_symbol_count,
   output logic [cmsc_pkg::COUNT_BITS-1:0]      rsp_context_total,
   // csr port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cmsc_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [cmsc_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [cmsc_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import cmsc_pkg::*;

   // csr: one register, context order; any write lands in it
   logic [ORDER_W-1:0] context_order_ff;
   logic               csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         context_order_ff <= ORDER_RESET;
      end else if (csr_write) begin
         context_order_ff <= pwdata[ORDER_W-1:0];
      end
   end

   // read back, misaligned offsets read as zero
   assign prdata = (paddr == ADDR_CONTEXT_ORDER) ? CSR_DATA_W'(context_order_ff) : '0;

   // controller and datapath
   cmsc_cmd_type    cmd;
   cmsc_status_type status;

   cmsc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   cmsc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .context_order     (context_order_ff),
      .req_char_in       (req_char_in),
      .rsp_strobe        (rsp_strobe),
      .rsp_letter_index  (rsp_letter_index),
      .rsp_context_index (rsp_context_index),
      .rsp_symbol_count  (rsp_symbol_count),
      .rsp_context_total (rsp_context_total)
   );

   // checks
   `CMSC_ASSERT_ALWAYS(a_no_strobe_after_reset, reset |=> !rsp_strobe, "strobe right after reset")
   `CMSC_ASSERT(a_strobe_follows_update, rsp_strobe |-> $past(cmd.update), "strobe without update")
   `CMSC_ASSERT(a_strobe_from_capture, rsp_strobe |-> $past(cmd.capture, 3), "strobe without capture")
   `CMSC_ASSERT(a_count_nz, rsp_strobe |-> (|rsp_symbol_count && |rsp_context_total), "zero count")
   `CMSC_ASSERT(a_busy_in_sweep, cmd.clear |-> busy, "idle during init sweep")

endmodule

// ===== tb/tb_context_model_symbol_counter.sv =====
`timescale 1ns / 1ps

module tb_context_model_symbol_counter;
   import cmsc_pkg::*;

   // cycles to let a letter finish after its last expected result has come
   localparam int SETTLE_CYCLES  = 8;
   // cycles with no transfer before the run is declared hung; the clear sweep
   // after reset counts toward this limit
   localparam int WATCHDOG_LIMIT = 90000;
   localparam int RANDOM_PER_PHASE = 230;

   typedef struct packed {
      logic [LETTER_W-1:0]   letter;
      logic [CTX_W-1:0]      ctx;
      logic [COUNT_BITS-1:0] sym_count;
      logic [COUNT_BITS-1:0] ctx_total;
   } count_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [CHAR_W-1:0]     req_char_in;
   logic                  rsp_strobe;
   logic [LETTER_W-1:0]   rsp_letter_index;
   logic [CTX_W-1:0]      rsp_context_index;
   logic [COUNT_BITS-1:0] rsp_symbol_count;
   logic [COUNT_BITS-1:0] rsp_context_total;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predictor state: own copy of the count tables, letter history and order
   logic [COUNT_BITS-1:0] letter_counts [SYM_SLOTS];
   logic [COUNT_BITS-1:0] ctx_totals [CTX_SLOTS];
   logic [LETTER_W-1:0]   last_letters [HIST_DEPTH];
   logic [ORDER_W-1:0]    order_reg;

   logic [CHAR_W-1:0] byte_queue [$];        // bytes waiting for the driver
   count_result_type  expected_counts [$];   // predicted results, oldest first
   count_result_type  predicted;
   count_result_type  oldest;

   bit                no_gaps;
   int                mismatches;
   int                bytes_sent;
   int                results_checked;
   int                csr_writes;
   int                idle_cycles;
   logic [COUNT_BITS-1:0] peak_count;
   logic [3:0]        orders_seen;

   context_model_symbol_counter dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_char_in       (req_char_in),
      .rsp_strobe        (rsp_strobe),
      .rsp_letter_index  (rsp_letter_index),
      .rsp_context_index (rsp_context_index),
      .rsp_symbol_count  (rsp_symbol_count),
      .rsp_context_total (rsp_context_total),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // one place for every mismatch report, the watchdog apart; only the first ten are printed
   task automatic flag_error(input string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         flag_error($sformatf("%s expected %0d (0x%0h), got %0d (0x%0h)",
                              name, want, want, got, got));
      end
   endtask

   // fold case, drop non-letters, bump the two counts and shift the history;
   // returns 1 when the byte gives a result
   function automatic bit count_letter(input logic [CHAR_W-1:0] ch,
                                       output count_result_type r);
      logic [CHAR_W-1:0]   c;
      logic [LETTER_W-1:0] letter;
      int                  k;
      int                  ctx;
      int                  sym;
      c = ch;
      if (c >= (CHAR_LOWER_A ^ CHAR_CASE_BIT) && c <= (CHAR_LOWER_Z ^ CHAR_CASE_BIT)) begin
         c = c | CHAR_CASE_BIT;
      end
      if (c < CHAR_LOWER_A || c > CHAR_LOWER_Z) begin
         return 1'b0;
      end
      letter = LETTER_W'(c - CHAR_LOWER_A);
      // orders above the supported depth saturate
      k = (order_reg > ORDER_MAX) ? ORDER_MAX : int'(order_reg);
      ctx = 0;
      // oldest letter is the most significant base-26 digit
      for (int i = k; i > 0; i--) begin
         ctx = ctx * ALPHABET + int'(last_letters[i-1]);
      end
      sym = ctx * ALPHABET + int'(letter);
      if (ctx_totals[ctx] != '1) begin
         ctx_totals[ctx] = ctx_totals[ctx] + 1'b1;
      end
      if (letter_counts[sym] != '1) begin
         letter_counts[sym] = letter_counts[sym] + 1'b1;
      end
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
         last_letters[i] = last_letters[i-1];
      end
      last_letters[0] = letter;
      r.letter    = letter;
      r.ctx       = CTX_W'(ctx);
      r.sym_count = letter_counts[sym];
      r.ctx_total = ctx_totals[ctx];
      return 1'b1;
   endfunction

   // mostly letters from the first span letters in either case, the rest any byte;
   // a narrow span piles up counts in a few contexts
   function automatic logic [CHAR_W-1:0] gen_byte(input int span);
      logic [CHAR_W-1:0] b;
      if ($urandom_range(99) < 70) begin
         b = CHAR_W'(CHAR_LOWER_A + $urandom_range(span - 1));
         if ($urandom_range(1) == 1) begin
            b = b ^ CHAR_CASE_BIT;
         end
      end else begin
         b = CHAR_W'($urandom_range(255));
      end
      return b;
   endfunction

   // driver: a transfer happens at an edge with start high and busy low
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            bytes_sent++;
            if (count_letter(req_char_in, predicted)) begin
               expected_counts = {expected_counts, predicted};
            end
         end
         // offer the next byte unless the current one is still held off
         if (!start || !busy) begin
            if (byte_queue.size() != 0 && (no_gaps || $urandom_range(99) >= 17)) begin
               start       <= 1'b1;
               req_char_in <= byte_queue.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobe is one result transfer, checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_counts.size() == 0) begin
            flag_error($sformatf("unexpected result letter %0d ctx %0d count %0d total %0d",
                                 rsp_letter_index, rsp_context_index,
                                 rsp_symbol_count, rsp_context_total));
         end else begin
            oldest = expected_counts.pop_front();
            check_field("letter_index", 32'(oldest.letter), 32'(rsp_letter_index));
            check_field("context_index", 32'(oldest.ctx), 32'(rsp_context_index));
            check_field("symbol_count", oldest.sym_count, rsp_symbol_count);
            check_field("context_total", oldest.ctx_total, rsp_context_total);
            if (oldest.sym_count > peak_count) begin
               peak_count = oldest.sym_count;
            end
            results_checked++;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // wait until every byte is taken and every result is in, then let the
   // block finish any trailing work before touching the register
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (byte_queue.size() != 0 || start || expected_counts.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (busy) begin
         @(negedge clock);
      end
   endtask

   // write the order with random upper bits, then read it back
   task automatic set_order(input logic [ORDER_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'($urandom());
      data[ORDER_W-1:0] = value;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_CONTEXT_ORDER;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // write lands at this edge; go straight into the read setup
      order_reg = value;
      orders_seen[value] = 1'b1;
      csr_writes++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      check_field("context_order readback", CSR_DATA_W'(value), prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      logic [ORDER_W-1:0] phase_orders [8];
      reset       = 1'b1;
      start       = 1'b0;
      req_char_in = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      no_gaps     = 1'b0;
      mismatches  = 0;
      bytes_sent  = 0;
      results_checked = 0;
      csr_writes  = 0;
      idle_cycles = 0;
      peak_count  = '0;
      // predictor reset: counts start at one, totals at zero, history all 'a'
      for (int i = 0; i < SYM_SLOTS; i++) begin
         letter_counts[i] = SYM_COUNT_INIT;
      end
      for (int i = 0; i < CTX_SLOTS; i++) begin
         ctx_totals[i] = CTX_TOTAL_INIT;
      end
      for (int i = 0; i < HIST_DEPTH; i++) begin
         last_letters[i] = '0;
      end
      order_reg   = ORDER_RESET;
      orders_seen = 4'b0000;
      orders_seen[ORDER_RESET] = 1'b1;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset order: letter ends in both cases, the
      // bytes just outside each letter range, high-bit bytes that alias letters
      byte_queue = '{8'h41, 8'h7a, 8'h5a, 8'h61, 8'h00, 8'hff, 8'h80, 8'h40,
                     8'h5b, 8'h60, 8'h7b, 8'h7f, 8'hc1, 8'he1, 8'h4d, 8'h6d,
                     8'h71, 8'h71, 8'h51};
      wait_idle();

      // phases walk through every order, both ends and the saturated value;
      // the history carries over each change
      phase_orders = '{2'd0, 2'd2, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd1};
      for (int p = 0; p < 8; p++) begin
         set_order(phase_orders[p]);
         no_gaps = (p == 3);
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            byte_queue = {byte_queue, gen_byte((p % 2 == 1) ? 3 : ALPHABET)};
         end
         wait_idle();
      end
      no_gaps = 1'b0;

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_counts.size() != 0) begin
         flag_error($sformatf("%0d results never arrived", expected_counts.size()));
      end
      $display("%0d bytes driven, %0d letter results checked, %0d order writes",
               bytes_sent, results_checked, csr_writes);
      $display("orders used (bit per order) %b, highest symbol count seen %0d",
               orders_seen, peak_count);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches in total", mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
